@@ sv/slli_pkg.sv @@
`default_nettype none

package slli_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REWIND = 2'd1,
    OP_NEXT   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Fixed field widths of the two channels.
  localparam int unsigned KeyFieldW   = 32;
  localparam int unsigned IndexFieldW = 8;

  // Input transaction payload.
  typedef struct packed {
    op_e                    operation;
    logic [KeyFieldW-1:0]   entry_key;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [IndexFieldW-1:0] entry_index;
    logic [KeyFieldW-1:0]   entry_key_out;
    logic                   has_entry;
    logic                   full_error;
  } out_t;

  // Command broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic insert;       // link a new entry into its sorted place
    logic rd_load;      // copy each entry into its read register
    logic rd_shift;     // move read registers one cell toward the head
    logic tok_advance;  // move the cursor token one entry toward the tail
    logic rewind;       // place the cursor token on the head entry
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/sorted_linked_list_insert_iterate.sv @@
// Sorted list of keyed entries, kept in a row of cells in ascending key order.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one operation per
// transaction: add a key, rewind the read cursor, read the next entry, or no
// operation. Every input transaction yields exactly one result transaction on
// the output channel (out_valid_o / out_ready_i / out_data_o), in order.
// An add is linked in by all cells in parallel and its result goes straight to
// the output queue, as are rewind, no operation, a refused add and a next at
// the end. A next that finds an entry copies the row into a read line and
// shifts it one cell per cycle toward the head until the cursor entry
// arrives; the block takes no new transaction during that scan.
// Entries are given table indexes in arrival order; equal keys keep arrival
// order. A full table refuses an add and flags full_error.
// Reset empties the list and parks the cursor at the end; it takes effect at
// once, with no clearing pass. Results go through a two-entry output queue, so
// one more transaction is taken while a result waits; when both entries are
// held, in_ready_o is low until the receiver takes one.
`default_nettype none

module sorted_linked_list_insert_iterate #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  slli_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slli_pkg::out_t out_data_o
);
  import slli_pkg::*;

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            cur_valid_q, cur_valid_d;

  cell_cmd_t       cmd;
  logic            accept;
  logic            push;
  out_t            push_data;
  logic            space;
  logic [KEY_BITS-1:0] new_key;
  logic [SlotW-1:0]    new_slot;

  logic                occ       [CAPACITY];
  logic                gt        [CAPACITY];
  logic                tok       [CAPACITY];
  logic [KEY_BITS-1:0] key       [CAPACITY];
  logic [SlotW-1:0]    slot      [CAPACITY];
  logic [KEY_BITS-1:0] rd_key    [CAPACITY];
  logic [SlotW-1:0]    rd_slot   [CAPACITY];
  logic                rd_tok    [CAPACITY];
  logic                rd_occ    [CAPACITY];
  logic                left_occ  [CAPACITY];
  logic                left_gt   [CAPACITY];
  logic                left_tok  [CAPACITY];
  logic [KEY_BITS-1:0] left_key  [CAPACITY];
  logic [SlotW-1:0]    left_slot [CAPACITY];
  logic [KEY_BITS-1:0] right_key [CAPACITY];
  logic [SlotW-1:0]    right_slot[CAPACITY];
  logic                right_tok [CAPACITY];
  logic                right_occ [CAPACITY];

  assign in_ready_o = (state_q == ST_IDLE) && space;
  assign accept     = in_valid_i && in_ready_o;
  assign new_key    = KEY_BITS'(in_data_i.entry_key);
  assign new_slot   = SlotW'(count_q);

  // Controller: decode the operation and sequence the read scan.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_valid_d = cur_valid_q;
    cmd         = '0;
    push        = 1'b0;
    push_data   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.operation)
            OP_ADD: begin
              push = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                push_data.full_error = 1'b1;
              end else begin
                cmd.insert            = 1'b1;
                push_data.entry_index = IndexFieldW'(count_q);
                count_d               = count_q + 1'b1;
              end
            end
            OP_REWIND: begin
              push        = 1'b1;
              cmd.rewind  = 1'b1;
              cur_valid_d = (count_q != '0);
            end
            OP_NEXT: begin
              if (cur_valid_q) begin
                cmd.rd_load = 1'b1;
                state_d     = ST_SCAN;
              end else begin
                push = 1'b1;
              end
            end
            OP_NOP: begin
              push = 1'b1;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_tok[0]) begin
          // The cursor entry sits at the head of the read line.
          push                    = 1'b1;
          push_data.entry_index   = IndexFieldW'(rd_slot[0]);
          push_data.entry_key_out = KeyFieldW'(rd_key[0]);
          push_data.has_entry     = 1'b1;
          cmd.tok_advance         = 1'b1;
          cur_valid_d             = rd_occ[1];
          state_d                 = ST_IDLE;
        end else begin
          cmd.rd_shift = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
    end
  end

  // Row of cells, one list position each, linked to both neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_occ[i]  = 1'b1;
      assign left_gt[i]   = 1'b0;
      assign left_tok[i]  = 1'b0;
      assign left_key[i]  = '0;
      assign left_slot[i] = '0;
    end else begin : g_left
      assign left_occ[i]  = occ[i-1];
      assign left_gt[i]   = gt[i-1];
      assign left_tok[i]  = tok[i-1];
      assign left_key[i]  = key[i-1];
      assign left_slot[i] = slot[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key[i]  = '0;
      assign right_slot[i] = '0;
      assign right_tok[i]  = 1'b0;
      assign right_occ[i]  = 1'b0;
    end else begin : g_right
      assign right_key[i]  = rd_key[i+1];
      assign right_slot[i] = rd_slot[i+1];
      assign right_tok[i]  = rd_tok[i+1];
      assign right_occ[i]  = rd_occ[i+1];
    end

    slli_cell #(
      .KEY_BITS (KEY_BITS),
      .SLOT_W   (SlotW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .cmd_i           (cmd),
      .first_i         (i == 0),
      .occ_i           (occ[i]),
      .new_key_i       (new_key),
      .new_slot_i      (new_slot),
      .left_occ_i      (left_occ[i]),
      .left_gt_i       (left_gt[i]),
      .left_tok_i      (left_tok[i]),
      .left_key_i      (left_key[i]),
      .left_slot_i     (left_slot[i]),
      .right_rd_key_i  (right_key[i]),
      .right_rd_slot_i (right_slot[i]),
      .right_rd_tok_i  (right_tok[i]),
      .right_rd_occ_i  (right_occ[i]),
      .gt_o            (gt[i]),
      .key_o           (key[i]),
      .slot_o          (slot[i]),
      .tok_o           (tok[i]),
      .rd_key_o        (rd_key[i]),
      .rd_slot_o       (rd_slot[i]),
      .rd_tok_o        (rd_tok[i]),
      .rd_occ_o        (rd_occ[i])
    );
  end

  // Output queue between the controller and the receiver.
  slli_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ sv/slli_cell.sv @@
`default_nettype none

module slli_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned SLOT_W   = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slli_pkg::cell_cmd_t   cmd_i,
  input  logic                  first_i,
  input  logic                  occ_i,
  input  logic [KEY_BITS-1:0]   new_key_i,
  input  logic [SLOT_W-1:0]     new_slot_i,
  input  logic                  left_occ_i,
  input  logic                  left_gt_i,
  input  logic                  left_tok_i,
  input  logic [KEY_BITS-1:0]   left_key_i,
  input  logic [SLOT_W-1:0]     left_slot_i,
  input  logic [KEY_BITS-1:0]   right_rd_key_i,
  input  logic [SLOT_W-1:0]     right_rd_slot_i,
  input  logic                  right_rd_tok_i,
  input  logic                  right_rd_occ_i,
  output logic                  gt_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic                  tok_o,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [SLOT_W-1:0]     rd_slot_o,
  output logic                  rd_tok_o,
  output logic                  rd_occ_o
);
  import slli_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                tok_q, tok_d;
  logic [KEY_BITS-1:0] rd_key_q, rd_key_d;
  logic [SLOT_W-1:0]   rd_slot_q, rd_slot_d;
  logic                rd_tok_q, rd_tok_d;
  logic                rd_occ_q, rd_occ_d;
  logic                take_new;

  // This entry lies after the insertion point when its key is strictly greater.
  assign gt_o = occ_i && (key_q > new_key_i);

  // The new entry lands in the first greater cell, or in the first free cell.
  assign take_new = !left_gt_i && (gt_o || (left_occ_i && !occ_i));

  // Entry and cursor token: shift toward the tail on insert; the token alone moves on advance or rewind.
  always_comb begin
    key_d  = key_q;
    slot_d = slot_q;
    tok_d  = tok_q;
    if (cmd_i.insert) begin
      if (left_gt_i) begin
        key_d  = left_key_i;
        slot_d = left_slot_i;
        tok_d  = left_tok_i;
      end else if (take_new) begin
        key_d  = new_key_i;
        slot_d = new_slot_i;
        tok_d  = 1'b0;
      end
    end else if (cmd_i.tok_advance) begin
      tok_d = left_tok_i && occ_i;
    end else if (cmd_i.rewind) begin
      tok_d = first_i && occ_i;
    end
  end

  // Read line: load a snapshot, then move it one cell toward the head per cycle while rd_shift is set.
  always_comb begin
    rd_key_d  = rd_key_q;
    rd_slot_d = rd_slot_q;
    rd_tok_d  = rd_tok_q;
    rd_occ_d  = rd_occ_q;
    if (cmd_i.rd_load) begin
      rd_key_d  = key_q;
      rd_slot_d = slot_q;
      rd_tok_d  = tok_q;
      rd_occ_d  = occ_i;
    end else if (cmd_i.rd_shift) begin
      rd_key_d  = right_rd_key_i;
      rd_slot_d = right_rd_slot_i;
      rd_tok_d  = right_rd_tok_i;
      rd_occ_d  = right_rd_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      rd_tok_q <= 1'b0;
      rd_occ_q <= 1'b0;
    end else begin
      tok_q    <= tok_d;
      rd_tok_q <= rd_tok_d;
      rd_occ_q <= rd_occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    slot_q    <= slot_d;
    rd_key_q  <= rd_key_d;
    rd_slot_q <= rd_slot_d;
  end

  assign key_o     = key_q;
  assign slot_o    = slot_q;
  assign tok_o     = tok_q;
  assign rd_key_o  = rd_key_q;
  assign rd_slot_o = rd_slot_q;
  assign rd_tok_o  = rd_tok_q;
  assign rd_occ_o  = rd_occ_q;

endmodule

`default_nettype wire

@@ sv/slli_outq.sv @@
`default_nettype none

module slli_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slli_pkg::out_t push_data_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slli_pkg::out_t out_data_o
);
  import slli_pkg::*;

  out_t main_q, main_d;
  out_t skid_q, skid_d;
  logic main_v_q, main_v_d;
  logic skid_v_q, skid_v_d;
  logic pop;

  assign pop = main_v_q && out_ready_i;

  // Two-entry queue: the skid entry takes a result while the output one waits.
  always_comb begin
    main_d   = main_q;
    skid_d   = skid_q;
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_d   = push_data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire
